FILE: rtl/hmtf_pkg.sv
// ----------------------------------------------------------------------------
// hmtf_pkg: shared definitions for the humidity/temperature frame decoder
// Holds the CRC-8 step function, the scaling constants, the frame status
// codes and the lane result type.
// ----------------------------------------------------------------------------
package hmtf_pkg;

  // CRC-8, polynomial x^8 + x^5 + x^4 + 1, init 0xFF, MSB first.
  localparam logic [7:0] CRC_POLY_LOW = 8'h31;
  localparam logic [7:0] CRC_INIT     = 8'hFF;

  // Full-scale raw reading and the rounding bias (half of full scale, rounded down).
  localparam int unsigned RAW_FULL  = 65535;
  localparam int unsigned RAW_HALF  = RAW_FULL / 2;

  // Spans and offset, in hundredths.
  localparam logic [14:0] TEMP_SPAN_CENTI   = 15'd17500;
  localparam logic [14:0] HUM_SPAN_CENTI    = 15'd10000;
  localparam logic [15:0] TEMP_OFFSET_CENTI = 16'd4500;

  // Widths of the fields.
  localparam int TEMP_W   = 15;
  localparam int HUM_W    = 14;
  localparam int STATUS_W = 2;
  localparam int SCALE_W  = 15;  // scaled value, 0 to 17500
  localparam int PROD_W   = 31;  // span times raw word, plus rounding bias

  // Frame status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_TEMP_CRC = 2'd1,
    ST_HUM_CRC  = 2'd2
  } frame_status_t;

  // What one lane reports to the merging stage.
  typedef struct packed {
    logic [SCALE_W-1:0] value;
    logic               crc_ok;
  } lane_res_t;

  // Fold one byte into the running CRC, one bit per step.
  function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    c = acc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY_LOW;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/hmtf_lane.sv
// ----------------------------------------------------------------------------
// hmtf_lane: one measurement lane
// Checks the CRC of one raw word a byte per stage and scales the word to
// hundredths, round(span * raw / 65535), over two pipeline stages.
// ----------------------------------------------------------------------------
module hmtf_lane (
  input  logic                     clk,
  input  logic                     en,
  input  logic [14:0]              span,
  input  logic [7:0]               msb,
  input  logic [7:0]               lsb,
  input  logic [7:0]               rx_crc,
  output hmtf_pkg::lane_res_t      res
);

  // First stage: product with rounding bias, CRC over the high byte.
  logic [hmtf_pkg::PROD_W-1:0] prod;
  logic [7:0]                  crc_hi;
  logic [7:0]                  lsb_a;
  logic [7:0]                  rx_crc_a;

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= hmtf_pkg::PROD_W'(span) * hmtf_pkg::PROD_W'({msb, lsb})
                  + hmtf_pkg::PROD_W'(hmtf_pkg::RAW_HALF);
      crc_hi   <= hmtf_pkg::crc8_byte(hmtf_pkg::CRC_INIT, msb);
      lsb_a    <= lsb;
      rx_crc_a <= rx_crc;
    end
  end

  // Divide by 65535: the estimate y >> 16 leaves a remainder of the low
  // half plus the estimate, which is below twice the divisor.
  logic [hmtf_pkg::SCALE_W-1:0] q_est;
  logic [16:0]                  rem;
  logic [hmtf_pkg::SCALE_W-1:0] quot;

  always_comb begin
    q_est = prod[hmtf_pkg::PROD_W-1:16];
    rem   = {1'b0, prod[15:0]} + 17'(q_est);
    quot  = (rem >= 17'(hmtf_pkg::RAW_FULL)) ? q_est + 1'b1 : q_est;
  end

  // Second stage: corrected quotient and the finished CRC compare.
  always_ff @(posedge clk) begin
    if (en) begin
      res.value  <= quot;
      res.crc_ok <= (hmtf_pkg::crc8_byte(crc_hi, lsb_a) == rx_crc_a);
    end
  end

endmodule

FILE: rtl/hmtf_merge.sv
// ----------------------------------------------------------------------------
// hmtf_merge: combines the two lanes into one result word
// Applies the temperature offset, picks the frame status with temperature
// checked first, and holds the result in the output register.
// ----------------------------------------------------------------------------
module hmtf_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  hmtf_pkg::lane_res_t temp_res,
  input  hmtf_pkg::lane_res_t hum_res,
  output logic                en,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata   // temp_centi[14:0], humidity_centi[28:15],
                                        // frame_status[30:29], zero[31]
);

  logic [15:0]                   temp_wide;
  logic [hmtf_pkg::TEMP_W-1:0]   temp_centi;
  logic [hmtf_pkg::HUM_W-1:0]    humidity_centi;
  hmtf_pkg::frame_status_t       status;

  // The whole pipeline moves whenever the output register can take a word.
  assign en = !m_tvalid || m_tready;

  // Offset, truncation and status priority.
  always_comb begin
    temp_wide      = 16'(temp_res.value) - hmtf_pkg::TEMP_OFFSET_CENTI;
    temp_centi     = temp_wide[hmtf_pkg::TEMP_W-1:0];
    humidity_centi = hum_res.value[hmtf_pkg::HUM_W-1:0];
    if (!temp_res.crc_ok) begin
      status = hmtf_pkg::ST_TEMP_CRC;
    end else if (!hum_res.crc_ok) begin
      status = hmtf_pkg::ST_HUM_CRC;
    end else begin
      status = hmtf_pkg::ST_OK;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= in_valid;
    end
  end

  // Output data register.
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {1'b0, status, humidity_centi, temp_centi};
    end
  end

endmodule

FILE: rtl/humidity_temp_frame_decoder.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder: six-byte sensor frame decoder
// Checks both CRC-8 bytes of a frame and converts the raw temperature and
// humidity words to hundredths of a degree and of a percent.
// ----------------------------------------------------------------------------
// A word accepted on s_tdata passes both lane stages before the output register holds it.
// Throughput: one frame per cycle; the two lanes and the merge stage are
// three register stages that all advance together whenever the output
// register is empty or being read.
// Reset: rst clears the stage valid flags only, so frames in flight are dropped
// and no frame is invented.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // temp_msb[7:0], temp_lsb[15:8], temp_crc[23:16],
                                 // hum_msb[31:24], hum_lsb[39:32], hum_crc[47:40]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // temp_centi[14:0], humidity_centi[28:15],
                                 // frame_status[30:29], zero[31]
);

  logic                en;
  logic                v_a;
  logic                v_b;
  hmtf_pkg::lane_res_t temp_res;
  hmtf_pkg::lane_res_t hum_res;

  assign s_tready = en;

  // Valid flags of the two lane stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
    end else if (en) begin
      v_a <= s_tvalid;
      v_b <= v_a;
    end
  end

  // Temperature lane.
  hmtf_lane u_temp_lane (
    .clk    (clk),
    .en     (en),
    .span   (hmtf_pkg::TEMP_SPAN_CENTI),
    .msb    (s_tdata[7:0]),
    .lsb    (s_tdata[15:8]),
    .rx_crc (s_tdata[23:16]),
    .res    (temp_res)
  );

  // Humidity lane.
  hmtf_lane u_hum_lane (
    .clk    (clk),
    .en     (en),
    .span   (hmtf_pkg::HUM_SPAN_CENTI),
    .msb    (s_tdata[31:24]),
    .lsb    (s_tdata[39:32]),
    .rx_crc (s_tdata[47:40]),
    .res    (hum_res)
  );

  // Merge and output register.
  hmtf_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v_b),
    .temp_res (temp_res),
    .hum_res  (hum_res),
    .en       (en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A word leaving the last lane stage lands in the output register.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (v_b && en) |=> m_tvalid)
    else $error("lane result dropped on the way to the output register");

  // Humidity never exceeds full scale.
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[28:15] <= 14'd10000))
    else $error("humidity out of range");

  // Temperature stays within the sensor span.
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[14:0]) >= -15'sd4500 &&
                  $signed(m_tdata[14:0]) <= 15'sd13000))
    else $error("temperature out of range");

  // Status is never the unused code, and the padding bit is zero.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[30:29] != 2'd3) && !m_tdata[31])
    else $error("bad status code or padding bit");

endmodule
